### src/pmconv_pkg.sv
// shared types, codes and defaults for the padded multichannel conv2d unit
package pmconv_pkg;

    // default sizes for the top level parameters
    localparam int MAX_IN_CHANNELS_DEF  = 4;
    localparam int MAX_OUT_CHANNELS_DEF = 4;
    localparam int MAX_IMAGE_HEIGHT_DEF = 32;
    localparam int MAX_IMAGE_WIDTH_DEF  = 32;
    localparam int MAX_KERNEL_SIZE_DEF  = 5;
    localparam int VALUE_BITS_DEF       = 16;

    // fixed field widths of the word ports
    localparam int KIND_W     = 2;
    localparam int CHAN_W     = 2;
    localparam int IDX_W      = 6;
    localparam int DATA_W     = 16;
    localparam int SUM_W      = 40;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int PAD_W      = 3;

    // largest zero border in use
    localparam int PAD_LIMIT = 4;

    // register reset values
    localparam logic [2:0] PAD_RESET     = 3'd2;
    localparam logic [5:0] IMG_H_RESET   = 6'd7;
    localparam logic [5:0] IMG_W_RESET   = 6'd7;
    localparam logic [2:0] IN_CH_RESET   = 3'd2;
    localparam logic [2:0] OUT_CH_RESET  = 3'd1;
    localparam logic [2:0] K_ROWS_RESET  = 3'd3;
    localparam logic [2:0] K_COLS_RESET  = 3'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_K_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_K_COLS = 3'd6;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OUTPUT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_WRITE_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUM_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE_ERR = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // per-tap control that travels with the memory read data
    typedef struct packed {
        logic active;
        logic tap_en;
        logic first;
        logic last;
    } t_tap_ctl;

    // index width for a count of n entries
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### src/pmconv_ram.sv
// generic single write port ram with registered read
module pmconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = pmconv_pkg::idx_bits(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/pmconv_mac.sv
// multiply and accumulate stage behind the image and weight memories
module pmconv_mac #(
    parameter int VALUE_BITS = pmconv_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [VALUE_BITS-1:0]           i_img_q,
    input  logic signed [VALUE_BITS-1:0]           i_wgt_q,
    input  pmconv_pkg::t_tap_ctl                   i_tap_ctl,
    output logic signed [pmconv_pkg::SUM_W-1:0]    o_acc,
    output logic                                   o_acc_done
);

    localparam int PW = 2 * VALUE_BITS;
    localparam int XW = PW + pmconv_pkg::SUM_W;

    pmconv_pkg::t_tap_ctl r_ctl;
    logic signed [PW-1:0] r_prod;
    logic signed [pmconv_pkg::SUM_W-1:0] r_acc;
    logic r_done;

    logic signed [XW-1:0] w_prod_ext;
    logic signed [pmconv_pkg::SUM_W-1:0] w_add;
    logic signed [pmconv_pkg::SUM_W-1:0] n_acc;

    // product wraps into the accumulator width
    assign w_prod_ext = XW'(r_prod);
    assign w_add = r_ctl.tap_en ? w_prod_ext[pmconv_pkg::SUM_W-1:0] : '0;

    // first tap restarts the sum
    always_comb begin
        n_acc = r_acc;
        if (r_ctl.active) begin
            n_acc = r_ctl.first ? w_add : (r_acc + w_add);
        end
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_tap_ctl;
            r_done <= r_ctl.active && r_ctl.last;
        end
    end

    // product and accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= i_img_q * i_wgt_q;
        r_acc  <= n_acc;
    end

    assign o_acc      = r_acc;
    assign o_acc_done = r_done;

endmodule

### src/pmconv_seq.sv
// item decode, memory writes and tap sequencer for output requests
module pmconv_seq #(
    parameter int MAX_IN_CHANNELS  = pmconv_pkg::MAX_IN_CHANNELS_DEF,
    parameter int MAX_OUT_CHANNELS = pmconv_pkg::MAX_OUT_CHANNELS_DEF,
    parameter int MAX_IMAGE_HEIGHT = pmconv_pkg::MAX_IMAGE_HEIGHT_DEF,
    parameter int MAX_IMAGE_WIDTH  = pmconv_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int MAX_KERNEL_SIZE  = pmconv_pkg::MAX_KERNEL_SIZE_DEF,
    parameter int VALUE_BITS       = pmconv_pkg::VALUE_BITS_DEF,
    localparam int HW     = $clog2(MAX_IMAGE_HEIGHT + 1),
    localparam int WW     = $clog2(MAX_IMAGE_WIDTH + 1),
    localparam int CIW    = $clog2(MAX_IN_CHANNELS + 1),
    localparam int COW    = $clog2(MAX_OUT_CHANNELS + 1),
    localparam int KSW    = $clog2(MAX_KERNEL_SIZE + 1),
    localparam int IMG_AW = pmconv_pkg::idx_bits(MAX_IN_CHANNELS * MAX_IMAGE_HEIGHT
                                                  * MAX_IMAGE_WIDTH),
    localparam int WGT_AW = pmconv_pkg::idx_bits(MAX_OUT_CHANNELS * MAX_IN_CHANNELS
                                                  * MAX_KERNEL_SIZE * MAX_KERNEL_SIZE)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input word
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pmconv_pkg::KIND_W-1:0]         i_kind,
    input  logic [pmconv_pkg::CHAN_W-1:0]         i_out_chan,
    input  logic [pmconv_pkg::CHAN_W-1:0]         i_in_chan,
    input  logic [pmconv_pkg::IDX_W-1:0]          i_row_index,
    input  logic [pmconv_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [pmconv_pkg::DATA_W-1:0]  i_data_value,
    // sizes in use
    input  logic [pmconv_pkg::PAD_W-1:0]          i_pad,
    input  logic [HW-1:0]                         i_img_h,
    input  logic [WW-1:0]                         i_img_w,
    input  logic [CIW-1:0]                        i_in_ch,
    input  logic [COW-1:0]                        i_out_ch,
    input  logic [KSW-1:0]                        i_k_rows,
    input  logic [KSW-1:0]                        i_k_cols,
    // result handoff
    input  logic                                  i_acc_done,
    input  logic                                  i_res_free,
    output logic                                  o_res_load,
    output logic [pmconv_pkg::STATUS_W-1:0]       o_res_status,
    // memory ports
    output logic                                  o_img_we,
    output logic [IMG_AW-1:0]                     o_img_waddr,
    output logic [IMG_AW-1:0]                     o_img_raddr,
    output logic                                  o_wgt_we,
    output logic [WGT_AW-1:0]                     o_wgt_waddr,
    output logic [WGT_AW-1:0]                     o_wgt_raddr,
    output logic [VALUE_BITS-1:0]                 o_wr_data,
    output pmconv_pkg::t_tap_ctl                  o_tap_ctl
);

    localparam int CIDX_W = pmconv_pkg::idx_bits(MAX_IN_CHANNELS);
    localparam int KIDX_W = pmconv_pkg::idx_bits(MAX_KERNEL_SIZE);
    localparam int RCW = ((pmconv_pkg::IDX_W > HW) ? pmconv_pkg::IDX_W : HW) + 3;
    localparam int CCW = ((pmconv_pkg::IDX_W > WW) ? pmconv_pkg::IDX_W : WW) + 3;
    localparam int IMG_PLANE = MAX_IMAGE_HEIGHT * MAX_IMAGE_WIDTH;

    pmconv_pkg::t_state r_state, n_state;
    logic [pmconv_pkg::STATUS_W-1:0] r_status, n_status;
    logic [pmconv_pkg::CHAN_W-1:0]   r_oc, n_oc;
    logic [pmconv_pkg::IDX_W-1:0]    r_row, n_row;
    logic [pmconv_pkg::IDX_W-1:0]    r_col, n_col;
    logic [CIDX_W-1:0]               r_c, n_c;
    logic [KIDX_W-1:0]               r_a, n_a;
    logic [KIDX_W-1:0]               r_b, n_b;
    pmconv_pkg::t_tap_ctl            r_tap_ctl, n_tap_ctl;

    logic w_accept;
    logic w_pix_ok, w_wgt_ok, w_out_ok;
    logic signed [RCW-1:0] w_oh;
    logic signed [CCW-1:0] w_ow;
    logic signed [RCW-1:0] w_ir;
    logic signed [CCW-1:0] w_icol;
    logic w_tap_en, w_first;
    logic w_last_b, w_last_a, w_last_c;
    logic [VALUE_BITS+pmconv_pkg::DATA_W-1:0] w_data_zx;

    assign w_accept   = i_in_valid && (r_state == pmconv_pkg::ST_IDLE);
    assign o_in_stall = (r_state != pmconv_pkg::ST_IDLE);

    // range checks of the incoming word
    assign w_pix_ok = (CIW'(i_in_chan) < i_in_ch)
                   && (int'(i_row_index) < int'(i_img_h))
                   && (int'(i_col_index) < int'(i_img_w));
    assign w_wgt_ok = (int'(i_out_chan) < int'(i_out_ch))
                   && (int'(i_in_chan) < int'(i_in_ch))
                   && (int'(i_row_index) < int'(i_k_rows))
                   && (int'(i_col_index) < int'(i_k_cols));
    assign w_oh = $signed(RCW'(i_img_h)) + $signed(RCW'({i_pad, 1'b0}))
                - $signed(RCW'(i_k_rows)) + $signed(RCW'(1));
    assign w_ow = $signed(CCW'(i_img_w)) + $signed(CCW'({i_pad, 1'b0}))
                - $signed(CCW'(i_k_cols)) + $signed(CCW'(1));
    assign w_out_ok = (int'(i_out_chan) < int'(i_out_ch))
                   && ($signed(RCW'(i_row_index)) < w_oh)
                   && ($signed(CCW'(i_col_index)) < w_ow);

    // write side of both memories
    assign w_data_zx   = {{VALUE_BITS{1'b0}}, i_data_value};
    assign o_wr_data   = w_data_zx[VALUE_BITS-1:0];
    assign o_img_we    = w_accept && (i_kind == pmconv_pkg::KIND_PIXEL) && w_pix_ok;
    assign o_wgt_we    = w_accept && (i_kind == pmconv_pkg::KIND_WEIGHT) && w_wgt_ok;
    assign o_img_waddr = IMG_AW'(int'(i_in_chan) * IMG_PLANE
                                 + int'(i_row_index) * MAX_IMAGE_WIDTH
                                 + int'(i_col_index));
    assign o_wgt_waddr = WGT_AW'(((int'(i_out_chan) * MAX_IN_CHANNELS + int'(i_in_chan))
                                  * MAX_KERNEL_SIZE + int'(i_row_index))
                                 * MAX_KERNEL_SIZE + int'(i_col_index));

    // current tap position in the padded image
    assign w_ir   = $signed(RCW'(r_row)) + $signed(RCW'(r_a)) - $signed(RCW'(i_pad));
    assign w_icol = $signed(CCW'(r_col)) + $signed(CCW'(r_b)) - $signed(CCW'(i_pad));
    assign w_tap_en = (w_ir >= 0) && (w_ir < $signed(RCW'(i_img_h)))
                   && (w_icol >= 0) && (w_icol < $signed(CCW'(i_img_w)));

    // read side of both memories
    assign o_img_raddr = IMG_AW'(int'(r_c) * IMG_PLANE + int'(w_ir) * MAX_IMAGE_WIDTH
                                 + int'(w_icol));
    assign o_wgt_raddr = WGT_AW'(((int'(r_oc) * MAX_IN_CHANNELS + int'(r_c))
                                  * MAX_KERNEL_SIZE + int'(r_a))
                                 * MAX_KERNEL_SIZE + int'(r_b));

    // tap loop limits
    assign w_last_b = ((KSW'(r_b) + KSW'(1)) == i_k_cols);
    assign w_last_a = ((KSW'(r_a) + KSW'(1)) == i_k_rows);
    assign w_last_c = ((CIW'(r_c) + CIW'(1)) == i_in_ch);
    assign w_first  = (r_c == '0) && (r_a == '0) && (r_b == '0);

    // next state
    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_oc      = r_oc;
        n_row     = r_row;
        n_col     = r_col;
        n_c       = r_c;
        n_a       = r_a;
        n_b       = r_b;
        n_tap_ctl = '0;
        unique case (r_state)
            pmconv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state  = pmconv_pkg::ST_DONE;
                    n_status = pmconv_pkg::STATUS_RANGE_ERR;
                    n_oc     = i_out_chan;
                    n_row    = i_row_index;
                    n_col    = i_col_index;
                    n_c      = '0;
                    n_a      = '0;
                    n_b      = '0;
                    unique case (i_kind)
                        pmconv_pkg::KIND_PIXEL: begin
                            if (w_pix_ok) begin
                                n_status = pmconv_pkg::STATUS_WRITE_OK;
                            end
                        end
                        pmconv_pkg::KIND_WEIGHT: begin
                            if (w_wgt_ok) begin
                                n_status = pmconv_pkg::STATUS_WRITE_OK;
                            end
                        end
                        pmconv_pkg::KIND_OUTPUT: begin
                            if (w_out_ok) begin
                                n_status = pmconv_pkg::STATUS_SUM_OK;
                                n_state  = pmconv_pkg::ST_RUN;
                            end
                        end
                        default: begin
                            n_status = pmconv_pkg::STATUS_RANGE_ERR;
                        end
                    endcase
                end
            end
            pmconv_pkg::ST_RUN: begin
                n_tap_ctl.active = 1'b1;
                n_tap_ctl.tap_en = w_tap_en;
                n_tap_ctl.first  = w_first;
                n_tap_ctl.last   = w_last_b && w_last_a && w_last_c;
                if (!w_last_b) begin
                    n_b = r_b + KIDX_W'(1);
                end else begin
                    n_b = '0;
                    if (!w_last_a) begin
                        n_a = r_a + KIDX_W'(1);
                    end else begin
                        n_a = '0;
                        if (!w_last_c) begin
                            n_c = r_c + CIDX_W'(1);
                        end else begin
                            n_c     = '0;
                            n_state = pmconv_pkg::ST_DRAIN;
                        end
                    end
                end
            end
            pmconv_pkg::ST_DRAIN: begin
                if (i_acc_done) begin
                    n_state = pmconv_pkg::ST_DONE;
                end
            end
            pmconv_pkg::ST_DONE: begin
                if (i_res_free) begin
                    n_state = pmconv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmconv_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmconv_pkg::ST_IDLE;
            r_tap_ctl <= '0;
            r_c       <= '0;
            r_a       <= '0;
            r_b       <= '0;
        end else begin
            r_state   <= n_state;
            r_tap_ctl <= n_tap_ctl;
            r_c       <= n_c;
            r_a       <= n_a;
            r_b       <= n_b;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_oc     <= n_oc;
        r_row    <= n_row;
        r_col    <= n_col;
    end

    assign o_res_load   = (r_state == pmconv_pkg::ST_DONE) && i_res_free;
    assign o_res_status = r_status;
    assign o_tap_ctl    = r_tap_ctl;

endmodule

### src/padded_multichannel_conv2d_unit.sv
// top level of the padded multichannel conv2d unit
//
// input channel: i_in_valid / o_in_stall carry one word: a pixel write, a weight
// write or an output pixel request. output channel: o_out_valid / i_out_stall
// return one word per input word, in order, with o_sum_value and o_status.
// sizes are set through i_cfg_we / i_cfg_index / i_cfg_data; the user must set
// them only while the unit is idle, which the unit itself does not enforce;
// out-of-range register values are clamped when used.
// a write or an out-of-range word goes from accept through the sequencer done state
// into the output register, and the next word is taken once the sequencer is idle
// again. an in-range output request steps the run state through input_channels *
// kernel_rows * kernel_cols taps, one tap per cycle through the single read port
// of each memory, padding taps included, then the multiply and accumulate
// pipeline drains.
// one word is in flight at a time; o_in_stall is high until its result has
// moved into the output register, which can still hold the previous result.
// when the receiver stalls, the result stays in the output register and a
// finished word waits in the unit, holding o_in_stall high.
// reset (synchronous, active low) empties the output register, returns the
// sequencer to idle and loads the register defaults; memories are not cleared.
module padded_multichannel_conv2d_unit #(
    parameter int MAX_IN_CHANNELS  = pmconv_pkg::MAX_IN_CHANNELS_DEF,
    parameter int MAX_OUT_CHANNELS = pmconv_pkg::MAX_OUT_CHANNELS_DEF,
    parameter int MAX_IMAGE_HEIGHT = pmconv_pkg::MAX_IMAGE_HEIGHT_DEF,
    parameter int MAX_IMAGE_WIDTH  = pmconv_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int MAX_KERNEL_SIZE  = pmconv_pkg::MAX_KERNEL_SIZE_DEF,
    parameter int VALUE_BITS       = pmconv_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input word
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pmconv_pkg::KIND_W-1:0]         i_kind,
    input  logic [pmconv_pkg::CHAN_W-1:0]         i_out_chan,
    input  logic [pmconv_pkg::CHAN_W-1:0]         i_in_chan,
    input  logic [pmconv_pkg::IDX_W-1:0]          i_row_index,
    input  logic [pmconv_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [pmconv_pkg::DATA_W-1:0]  i_data_value,
    // output word
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pmconv_pkg::SUM_W-1:0]   o_sum_value,
    output logic [pmconv_pkg::STATUS_W-1:0]       o_status,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [pmconv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmconv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int HW  = $clog2(MAX_IMAGE_HEIGHT + 1);
    localparam int WW  = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int CIW = $clog2(MAX_IN_CHANNELS + 1);
    localparam int COW = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int KSW = $clog2(MAX_KERNEL_SIZE + 1);
    localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_IMAGE_HEIGHT * MAX_IMAGE_WIDTH;
    localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS
                             * MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
    localparam int IMG_AW = pmconv_pkg::idx_bits(IMG_DEPTH);
    localparam int WGT_AW = pmconv_pkg::idx_bits(WGT_DEPTH);

    // configuration registers
    logic [2:0] r_pad, r_in_ch, r_out_ch, r_k_rows, r_k_cols;
    logic [5:0] r_img_h, r_img_w;

    // sizes in use
    logic [pmconv_pkg::PAD_W-1:0] w_pad;
    logic [HW-1:0]  w_img_h;
    logic [WW-1:0]  w_img_w;
    logic [CIW-1:0] w_in_ch;
    logic [COW-1:0] w_out_ch;
    logic [KSW-1:0] w_k_rows, w_k_cols;

    // internal connections
    logic w_img_we, w_wgt_we;
    logic [IMG_AW-1:0] w_img_waddr, w_img_raddr;
    logic [WGT_AW-1:0] w_wgt_waddr, w_wgt_raddr;
    logic [VALUE_BITS-1:0] w_wr_data, w_img_q, w_wgt_q;
    pmconv_pkg::t_tap_ctl w_tap_ctl;
    logic signed [pmconv_pkg::SUM_W-1:0] w_acc;
    logic w_acc_done, w_res_free, w_res_load;
    logic [pmconv_pkg::STATUS_W-1:0] w_res_status;

    // output register
    logic r_out_valid;
    logic signed [pmconv_pkg::SUM_W-1:0] r_sum;
    logic [pmconv_pkg::STATUS_W-1:0] r_status;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad    <= pmconv_pkg::PAD_RESET;
            r_img_h  <= pmconv_pkg::IMG_H_RESET;
            r_img_w  <= pmconv_pkg::IMG_W_RESET;
            r_in_ch  <= pmconv_pkg::IN_CH_RESET;
            r_out_ch <= pmconv_pkg::OUT_CH_RESET;
            r_k_rows <= pmconv_pkg::K_ROWS_RESET;
            r_k_cols <= pmconv_pkg::K_COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmconv_pkg::CFG_PAD:    r_pad    <= i_cfg_data[2:0];
                pmconv_pkg::CFG_IMG_H:  r_img_h  <= i_cfg_data;
                pmconv_pkg::CFG_IMG_W:  r_img_w  <= i_cfg_data;
                pmconv_pkg::CFG_IN_CH:  r_in_ch  <= i_cfg_data[2:0];
                pmconv_pkg::CFG_OUT_CH: r_out_ch <= i_cfg_data[2:0];
                pmconv_pkg::CFG_K_ROWS: r_k_rows <= i_cfg_data[2:0];
                pmconv_pkg::CFG_K_COLS: r_k_cols <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // clamp registers into their ranges
    assign w_pad = (int'(r_pad) > pmconv_pkg::PAD_LIMIT)
                 ? pmconv_pkg::PAD_W'(pmconv_pkg::PAD_LIMIT) : r_pad;
    assign w_img_h = (r_img_h == '0) ? HW'(1)
                   : (int'(r_img_h) > MAX_IMAGE_HEIGHT) ? HW'(MAX_IMAGE_HEIGHT)
                   : HW'(r_img_h);
    assign w_img_w = (r_img_w == '0) ? WW'(1)
                   : (int'(r_img_w) > MAX_IMAGE_WIDTH) ? WW'(MAX_IMAGE_WIDTH)
                   : WW'(r_img_w);
    assign w_in_ch = (r_in_ch == '0) ? CIW'(1)
                   : (int'(r_in_ch) > MAX_IN_CHANNELS) ? CIW'(MAX_IN_CHANNELS)
                   : CIW'(r_in_ch);
    assign w_out_ch = (r_out_ch == '0) ? COW'(1)
                    : (int'(r_out_ch) > MAX_OUT_CHANNELS) ? COW'(MAX_OUT_CHANNELS)
                    : COW'(r_out_ch);
    assign w_k_rows = (r_k_rows == '0) ? KSW'(1)
                    : (int'(r_k_rows) > MAX_KERNEL_SIZE) ? KSW'(MAX_KERNEL_SIZE)
                    : KSW'(r_k_rows);
    assign w_k_cols = (r_k_cols == '0) ? KSW'(1)
                    : (int'(r_k_cols) > MAX_KERNEL_SIZE) ? KSW'(MAX_KERNEL_SIZE)
                    : KSW'(r_k_cols);

    // sequencer
    pmconv_seq #(
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
        .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
        .MAX_KERNEL_SIZE  (MAX_KERNEL_SIZE),
        .VALUE_BITS       (VALUE_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_out_chan   (i_out_chan),
        .i_in_chan    (i_in_chan),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_data_value (i_data_value),
        .i_pad        (w_pad),
        .i_img_h      (w_img_h),
        .i_img_w      (w_img_w),
        .i_in_ch      (w_in_ch),
        .i_out_ch     (w_out_ch),
        .i_k_rows     (w_k_rows),
        .i_k_cols     (w_k_cols),
        .i_acc_done   (w_acc_done),
        .i_res_free   (w_res_free),
        .o_res_load   (w_res_load),
        .o_res_status (w_res_status),
        .o_img_we     (w_img_we),
        .o_img_waddr  (w_img_waddr),
        .o_img_raddr  (w_img_raddr),
        .o_wgt_we     (w_wgt_we),
        .o_wgt_waddr  (w_wgt_waddr),
        .o_wgt_raddr  (w_wgt_raddr),
        .o_wr_data    (w_wr_data),
        .o_tap_ctl    (w_tap_ctl)
    );

    // image memory
    pmconv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (IMG_DEPTH)
    ) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (w_img_we),
        .i_waddr (w_img_waddr),
        .i_wdata (w_wr_data),
        .i_raddr (w_img_raddr),
        .o_rdata (w_img_q)
    );

    // weight memory
    pmconv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WGT_DEPTH)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (w_wgt_waddr),
        .i_wdata (w_wr_data),
        .i_raddr (w_wgt_raddr),
        .o_rdata (w_wgt_q)
    );

    // multiply and accumulate
    pmconv_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_img_q    ($signed(w_img_q)),
        .i_wgt_q    ($signed(w_wgt_q)),
        .i_tap_ctl  (w_tap_ctl),
        .o_acc      (w_acc),
        .o_acc_done (w_acc_done)
    );

    // output register takes a new word when empty or being drained
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status <= w_res_status;
            r_sum    <= (w_res_status == pmconv_pkg::STATUS_SUM_OK) ? w_acc : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_value = r_sum;
    assign o_status    = r_status;

endmodule

### src/pmconv_chk.sv
// port level checker for the padded multichannel conv2d unit, with its bind
module pmconv_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [pmconv_pkg::SUM_W-1:0]  o_sum_value,
    input logic [pmconv_pkg::STATUS_W-1:0]      o_status
);

    // reset empties the output and frees the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sum_value)
                                       && $stable(o_status))
        else $error("stalled output word changed");

    // an accepted word keeps the unit busy the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted word");

    // a new result only appears while a word is in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no word in flight");

    // only a computed output carries a sum
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != pmconv_pkg::STATUS_SUM_OK) |-> (o_sum_value == '0))
        else $error("nonzero sum on a write or error word");

endmodule

bind padded_multichannel_conv2d_unit pmconv_chk u_pmconv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sum_value (o_sum_value),
    .o_status    (o_status)
);
